>>> design/tsn_pkg.sv
`default_nettype none

package tsn_pkg;

  // Table size default and field widths
  localparam int unsigned NUM_FUNCS_DEF = 18;
  localparam int unsigned BYTE_W        = 8;

  // Flag byte layout: level in bits 1:0, acknowledge in bit 7
  localparam logic [1:0] LVL_NOSUPPORT  = 2'd0;
  localparam logic [1:0] LVL_CANTCHANGE = 2'd1;
  localparam logic [1:0] LVL_VARIABLE   = 2'd2;
  localparam logic [1:0] LVL_DEFAULT    = 2'd3;
  localparam int unsigned ACK_POS       = 7;

  // Request types of an input item
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_CLIENT = 2'd1;
  localparam logic [1:0] REQ_LOCAL  = 2'd2;

  // Reset value of the disabled character register
  localparam logic [7:0] DISABLED_CHAR_RST = 8'hFF;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [7:0] dflt_flags;
    logic [7:0] dflt_value;
    logic       changeable;
    logic [7:0] cur_flags;
    logic [7:0] cur_value;
    logic [7:0] term_char;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Operation applied by the entry unit
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_UNKNOWN,
    OP_CLIENT,
    OP_RESTORE,
    OP_LIST,
    OP_LSET,
    OP_LCHECK
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_e;

  // Result of the entry unit for one entry
  typedef struct packed {
    logic       we;
    logic       emit;
    logic [7:0] flags;
    logic [7:0] value;
    entry_t     entry;
  } unit_res_t;

endpackage

`default_nettype wire

>>> design/telnet_slc_negotiator_core.sv
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// request   | in        | in_valid_i/in_ready_o | req_type, func_code, flags_in, char_value,
//           |           |                      | can_change
// response  | out       | out_valid_o/out_ready_i | out_func, out_flags, out_value, last
// config    | in        | cfg_we_i (no wait)   | cfg_wdata_i (disabled character)
//
// Each table access is a RAM read, then an evaluate and write back.
// Load and client triplet items make one access; a function zero restore or list walks
// the table; a local change writes, then walks it. The block takes one item at a time.
// Reset clears the table valid bits and sets the disabled character to 255; entries
// that were never written read as zero, so no clearing pass is needed.
// A stalled response holds the walk: one triplet is kept back to mark the last one.

module telnet_slc_negotiator_core #(
  parameter int unsigned NUM_FUNCS = tsn_pkg::NUM_FUNCS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] func_code_i,
  input  wire logic [7:0] flags_in_i,
  input  wire logic [7:0] char_value_i,
  input  wire logic       can_change_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_func_o,
  output logic      [7:0] out_flags_o,
  output logic      [7:0] out_value_o,
  output logic            last_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FUNCS - 1);
  localparam logic [7:0] FUNC_MAX = 8'(NUM_FUNCS);

  tsn_pkg::state_e    state_q, state_d;
  tsn_pkg::op_e       op_q, dec_op;
  tsn_pkg::entry_t    rd_entry;
  tsn_pkg::unit_res_t res;

  logic [IDX_W-1:0]     idx_q, dec_idx;
  logic                 walk_q, dec_walk;
  logic [7:0]           func_q, flags_q, value_q;
  logic                 chg_q;
  logic [7:0]           dis_char_q;
  logic [NUM_FUNCS-1:0] valid_q;
  logic                 rvalid_q;
  logic [tsn_pkg::ENTRY_W-1:0] ram_rdata;

  logic       pend_valid_q;
  logic [7:0] pend_func_q, pend_flags_q, pend_value_q;

  logic in_accept, in_range, out_free, eval_stall, eval_go;
  logic walk_more, ram_re, ram_we, push_mid, push_last, pend_load, flush_go;

  // Decode an incoming item into an operation
  assign in_range = (func_code_i != 8'd0) && (func_code_i <= FUNC_MAX);

  always_comb begin
    dec_op   = tsn_pkg::OP_NONE;
    dec_walk = 1'b0;
    dec_idx  = IDX_W'(func_code_i - 8'd1);
    unique case (req_type_i)
      tsn_pkg::REQ_LOAD: begin
        if (in_range) begin
          dec_op = tsn_pkg::OP_LOAD;
        end
      end
      tsn_pkg::REQ_CLIENT: begin
        if (func_code_i > FUNC_MAX) begin
          dec_op = tsn_pkg::OP_UNKNOWN;
        end else if (func_code_i == 8'd0) begin
          dec_idx  = '0;
          dec_walk = 1'b1;
          if (flags_in_i[1:0] == tsn_pkg::LVL_DEFAULT) begin
            dec_op = tsn_pkg::OP_RESTORE;
          end else if (flags_in_i[1:0] == tsn_pkg::LVL_VARIABLE) begin
            dec_op = tsn_pkg::OP_LIST;
          end
        end else begin
          dec_op = tsn_pkg::OP_CLIENT;
        end
      end
      tsn_pkg::REQ_LOCAL: begin
        if (in_range) begin
          dec_op = tsn_pkg::OP_LSET;
        end else begin
          dec_op   = tsn_pkg::OP_LCHECK;
          dec_walk = 1'b1;
          dec_idx  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer control
  assign in_ready_o = (state_q == tsn_pkg::S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign walk_more  = walk_q && (idx_q != IDX_LAST);

  always_comb begin
    ram_re     = (state_q == tsn_pkg::S_READ);
    eval_stall = res.emit && pend_valid_q && !out_free;
    eval_go    = (state_q == tsn_pkg::S_EVAL) && !eval_stall;
    ram_we     = eval_go && res.we;
    pend_load  = eval_go && res.emit;
    push_mid   = pend_load && pend_valid_q;
    flush_go   = (state_q == tsn_pkg::S_FLUSH) && (!pend_valid_q || out_free);
    push_last  = flush_go && pend_valid_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsn_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (dec_op == tsn_pkg::OP_NONE) ? tsn_pkg::S_FLUSH : tsn_pkg::S_READ;
        end
      end
      tsn_pkg::S_READ: begin
        state_d = tsn_pkg::S_EVAL;
      end
      tsn_pkg::S_EVAL: begin
        if (eval_go) begin
          state_d = ((op_q == tsn_pkg::OP_LSET) || walk_more) ?
                    tsn_pkg::S_READ : tsn_pkg::S_FLUSH;
        end
      end
      tsn_pkg::S_FLUSH: begin
        if (flush_go) begin
          state_d = tsn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tsn_pkg::S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, operation, walk index, valid bits, disabled character, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tsn_pkg::S_IDLE;
      op_q       <= tsn_pkg::OP_NONE;
      walk_q     <= 1'b0;
      idx_q      <= '0;
      valid_q    <= '0;
      dis_char_q <= tsn_pkg::DISABLED_CHAR_RST;
      pend_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dis_char_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        op_q   <= dec_op;
        walk_q <= dec_walk;
        idx_q  <= dec_idx;
      end else if (eval_go) begin
        // after the local write, walk the whole table
        if (op_q == tsn_pkg::OP_LSET) begin
          op_q   <= tsn_pkg::OP_LCHECK;
          walk_q <= 1'b1;
          idx_q  <= '0;
        end else if (walk_more) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Item payload, read valid bit, pending triplet and output register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= func_code_i;
      flags_q <= flags_in_i;
      value_q <= char_value_i;
      chg_q   <= can_change_i;
    end
    if (ram_re) begin
      rvalid_q <= valid_q[idx_q];
    end
    if (pend_load) begin
      pend_func_q  <= walk_q ? (8'(idx_q) + 8'd1) : func_q;
      pend_flags_q <= res.flags;
      pend_value_q <= res.value;
    end
    if (push_mid || push_last) begin
      out_func_o  <= pend_func_q;
      out_flags_o <= pend_flags_q;
      out_value_o <= pend_value_q;
      last_o      <= push_last;
    end
  end

  // Table storage
  tsn_ram #(
    .WIDTH(tsn_pkg::ENTRY_W),
    .DEPTH(NUM_FUNCS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(res.entry),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // Entries never written read as zero
  assign rd_entry = rvalid_q ? tsn_pkg::entry_t'(ram_rdata) : '0;

  tsn_entry_unit u_unit (
    .op_i           (op_q),
    .entry_i        (rd_entry),
    .flags_i        (flags_q),
    .value_i        (value_q),
    .chg_i          (chg_q),
    .disabled_char_i(dis_char_q),
    .res_o          (res)
  );

endmodule

`default_nettype wire

>>> design/tsn_ram.sv
`default_nettype none

module tsn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/tsn_entry_unit.sv
`default_nettype none

module tsn_entry_unit (
  input  wire tsn_pkg::op_e       op_i,
  input  wire tsn_pkg::entry_t    entry_i,
  input  wire logic [7:0]         flags_i,
  input  wire logic [7:0]         value_i,
  input  wire logic               chg_i,
  input  wire logic [7:0]         disabled_char_i,
  output tsn_pkg::unit_res_t      res_o
);

  logic [1:0] his;
  logic [1:0] mine;
  logic [1:0] cur_lvl;
  logic       ack;

  assign his     = flags_i[1:0];
  assign mine    = entry_i.dflt_flags[1:0];
  assign cur_lvl = entry_i.cur_flags[1:0];
  assign ack     = flags_i[tsn_pkg::ACK_POS];

  // Evaluate one entry for the requested operation
  always_comb begin
    res_o       = '0;
    res_o.entry = entry_i;
    unique case (op_i)
      tsn_pkg::OP_NONE: begin
      end
      tsn_pkg::OP_LOAD: begin
        res_o.entry.dflt_flags = flags_i;
        res_o.entry.dflt_value = value_i;
        res_o.entry.changeable = chg_i;
        res_o.entry.cur_flags  = '0;
        res_o.entry.cur_value  = '0;
        res_o.entry.term_char  = value_i;
        res_o.we               = 1'b1;
      end
      tsn_pkg::OP_UNKNOWN: begin
        res_o.emit = 1'b1;
      end
      tsn_pkg::OP_RESTORE: begin
        res_o.entry.cur_value = entry_i.dflt_value;
        res_o.entry.cur_flags = (entry_i.dflt_value == disabled_char_i) ?
                                8'd0 : entry_i.dflt_flags;
        if (entry_i.changeable) begin
          res_o.entry.term_char = entry_i.dflt_value;
        end
        res_o.we    = 1'b1;
        res_o.emit  = (mine != tsn_pkg::LVL_NOSUPPORT);
        res_o.flags = res_o.entry.cur_flags;
        res_o.value = res_o.entry.cur_value;
      end
      tsn_pkg::OP_LIST: begin
        res_o.emit  = (mine != tsn_pkg::LVL_NOSUPPORT);
        res_o.flags = entry_i.cur_flags;
        res_o.value = entry_i.cur_value;
      end
      tsn_pkg::OP_LSET: begin
        res_o.entry.term_char = value_i;
        res_o.we              = 1'b1;
      end
      tsn_pkg::OP_LCHECK: begin
        if (entry_i.changeable && (entry_i.term_char != entry_i.cur_value)) begin
          res_o.entry.cur_value = entry_i.term_char;
          res_o.entry.cur_flags = (entry_i.term_char == disabled_char_i) ?
                                  8'd0 : entry_i.dflt_flags;
          res_o.we    = 1'b1;
          res_o.emit  = 1'b1;
          res_o.flags = res_o.entry.cur_flags;
          res_o.value = res_o.entry.cur_value;
        end
      end
      tsn_pkg::OP_CLIENT: begin
        // drop matching or acknowledged triplets
        if (!ack && !((his == cur_lvl) && (value_i == entry_i.cur_value))) begin
          res_o.we   = 1'b1;
          res_o.emit = 1'b1;
          if (his == tsn_pkg::LVL_NOSUPPORT) begin
            res_o.entry.cur_flags = flags_i;
            res_o.entry.cur_value = disabled_char_i;
            res_o.flags           = flags_i | 8'h80;
            res_o.value           = value_i;
          end else if (his == tsn_pkg::LVL_DEFAULT) begin
            res_o.entry.cur_flags = (mine == tsn_pkg::LVL_NOSUPPORT) ?
                                    8'd0 : entry_i.dflt_flags;
            res_o.entry.cur_value = entry_i.dflt_value;
            res_o.flags           = res_o.entry.cur_flags;
            res_o.value           = entry_i.dflt_value;
          end else if (entry_i.changeable) begin
            res_o.entry.cur_flags = flags_i;
            res_o.entry.cur_value = value_i;
            res_o.entry.term_char = value_i;
            res_o.flags           = flags_i | 8'h80;
            res_o.value           = value_i;
          end else if (mine == tsn_pkg::LVL_DEFAULT) begin
            res_o.entry.cur_flags = flags_i;
            res_o.entry.cur_value = value_i;
            res_o.flags           = flags_i | 8'h80;
            res_o.value           = value_i;
          end else if ((his == tsn_pkg::LVL_CANTCHANGE) &&
                       (mine == tsn_pkg::LVL_CANTCHANGE)) begin
            res_o.entry.cur_flags = {flags_i[7:2], tsn_pkg::LVL_NOSUPPORT};
            res_o.flags           = res_o.entry.cur_flags;
            res_o.value           = value_i;
          end else begin
            res_o.entry.cur_flags = {flags_i[7:2], mine};
            res_o.flags           = res_o.entry.cur_flags;
            res_o.value           = value_i;
            if (mine == tsn_pkg::LVL_CANTCHANGE) begin
              res_o.entry.cur_value = entry_i.dflt_value;
              res_o.value           = entry_i.dflt_value;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
